// File: design/ksl_pkg.sv
// ----------------------------------------------------------------------------
// ksl_pkg: shared definitions for the k-subset unranking block
// Field widths, register indexes, reset values, the controller/datapath
// interface structs and an elaboration-time binomial helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ksl_pkg;

	localparam int RANK_W      = 30;
	localparam int CFG_W       = 6;
	localparam int IDX_W       = 2;
	localparam int MAX_SET_DEF = 32;

	localparam logic [IDX_W-1:0] REG_SET_SIZE    = 2'd0;
	localparam logic [IDX_W-1:0] REG_SUBSET_SIZE = 2'd1;

	localparam logic [CFG_W-1:0] SET_SIZE_RST    = 6'd32;
	localparam logic [CFG_W-1:0] SUBSET_SIZE_RST = 6'd1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic check;
		logic step;
	} ksl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic err;
		logic done;
	} ksl_stat_t;

	// exact binomial built from pascal rows, used at elaboration only
	function automatic longint unsigned binom(input int a, input int b);
		longint unsigned row [0:63];
		int i;
		int j;
		for (j = 0; j < 64; j++) begin
			row[j] = 0;
		end
		row[0] = 1;
		for (i = 1; i <= a; i++) begin
			for (j = i; j >= 1; j--) begin
				row[j] = row[j] + row[j-1];
			end
		end
		if (b < 0 || b > a) begin
			return 0;
		end
		return row[b];
	endfunction

endpackage

`default_nettype wire

// File: design/ksl_ctrl.sv
// ----------------------------------------------------------------------------
// ksl_ctrl: sequencing controller
// Walks each request through load, range check and the candidate walk,
// issuing one command per cycle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ksl_ctrl import ksl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ksl_stat_t stat,
	output ksl_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CHECK = 3'b010,
		S_STEP  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		cmd       = '0;
		state_nx  = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_nx  = stat.err ? S_IDLE : S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (stat.done) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: design/ksl_dp.sv
// ----------------------------------------------------------------------------
// ksl_dp: unranking datapath
// Holds the configuration, the remaining rank and the walk position in
// pascal's triangle; a two-port binomial rom feeds both next candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module ksl_dp import ksl_pkg::*; #(
	parameter int MAX_SET = MAX_SET_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [RANK_W-1:0] rank,
	input  ksl_cmd_t          cmd,
	output ksl_stat_t         stat,
	output logic              valid,
	output logic [CFG_W-1:0]  element,
	output logic [CFG_W-1:0]  position,
	output logic              last,
	output logic              error
);

	localparam int ROWS = MAX_SET + 1;
	localparam int DEPTH = ROWS * ROWS;
	localparam int AW = $clog2(DEPTH);
	localparam longint unsigned CMAX = binom(MAX_SET, MAX_SET / 2);
	localparam int BW = $clog2(CMAX + 1);
	localparam int CMPW = (BW > RANK_W) ? BW : RANK_W;
	localparam int SW = CMPW + 1;
	localparam logic [CFG_W-1:0] MAXN = CFG_W'(MAX_SET);

	typedef logic [BW-1:0] rom_t [DEPTH];

	// row a, column b holds C(a,b); zero where b > a
	function automatic rom_t build_rom();
		rom_t t;
		longint unsigned row [0:63];
		int a;
		int b;
		for (b = 0; b < 64; b++) begin
			row[b] = 0;
		end
		row[0] = 1;
		for (a = 0; a < ROWS; a++) begin
			if (a > 0) begin
				for (b = a; b >= 1; b--) begin
					row[b] = row[b] + row[b-1];
				end
			end
			for (b = 0; b < ROWS; b++) begin
				t[a*ROWS+b] = BW'(row[b]);
			end
		end
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	// out-of-range coordinates land on entry zero, never used in that case
	function automatic logic [AW-1:0] rom_addr(input logic [CFG_W-1:0] a,
	                                           input logic [CFG_W-1:0] b);
		if (a > MAXN || b > MAXN) begin
			return '0;
		end
		return AW'(int'(a) * ROWS + int'(b));
	endfunction

	logic [CFG_W-1:0]  n_q;
	logic [CFG_W-1:0]  k_q;
	logic [RANK_W-1:0] r_q;
	logic [CFG_W-1:0]  a_q;
	logic [CFG_W-1:0]  b_q;
	logic [BW-1:0]     y_q;
	logic [BW-1:0]     p0_q;
	logic [BW-1:0]     p1_q;
	logic              cfg_bad_q;
	logic              valid_q;
	logic [CFG_W-1:0]  element_q;
	logic [CFG_W-1:0]  position_q;
	logic              last_q;
	logic              error_q;

	logic              take;
	logic              err;
	logic [CFG_W-1:0]  ra;
	logic [CFG_W-1:0]  rb;
	logic [AW-1:0]     addr0;
	logic [AW-1:0]     addr1;
	logic [SW-1:0]     total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= SET_SIZE_RST;
			k_q <= SUBSET_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SET_SIZE:    n_q <= cfg_data;
				REG_SUBSET_SIZE: k_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// skip the candidate while its block of subsets lies wholly below the rank
	assign take = (CMPW'(y_q) <= CMPW'(r_q)) && (a_q != '0);

	// C(n,k) = C(n-1,k) + C(n-1,k-1), both read at load
	assign total = SW'(p0_q) + SW'(p1_q);
	assign err   = cfg_bad_q || (SW'(r_q) >= total);

	assign stat.err  = err;
	assign stat.done = !take && (b_q == '0);

	// rom reads the two successors of the next walk position
	always_comb begin
		ra = a_q - 6'd1;
		rb = b_q;
		if (cmd.load) begin
			ra = n_q - 6'd1;
			rb = k_q;
		end else if (cmd.step) begin
			ra = a_q - 6'd2;
			rb = take ? b_q : (b_q - 6'd1);
		end
	end

	assign addr0 = rom_addr(ra, rb);
	assign addr1 = rom_addr(ra, rb - 6'd1);

	always_ff @(posedge clk) begin
		p0_q <= ROM[addr0];
		p1_q <= ROM[addr1];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q       <= rank;
			a_q       <= n_q - 6'd1;
			b_q       <= k_q - 6'd1;
			cfg_bad_q <= (n_q > MAXN) || (k_q == '0) || (k_q > n_q);
		end
		if (cmd.check) begin
			y_q <= p1_q;
			if (err) begin
				element_q  <= '0;
				position_q <= 6'd1;
				last_q     <= 1'b1;
				error_q    <= 1'b1;
			end
		end
		if (cmd.step) begin
			a_q <= a_q - 6'd1;
			if (take) begin
				r_q <= RANK_W'(CMPW'(r_q) - CMPW'(y_q));
				y_q <= p0_q;
			end else begin
				b_q        <= b_q - 6'd1;
				y_q        <= p1_q;
				element_q  <= n_q - a_q;
				position_q <= k_q - b_q;
				last_q     <= (b_q == '0);
				error_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (cmd.check && err) || (cmd.step && !take);
		end
	end

	assign valid    = valid_q;
	assign element  = element_q;
	assign position = position_q;
	assign last     = last_q;
	assign error    = error_q;

endmodule

`default_nettype wire

// File: design/ksubset_lex_unrank.sv
// ----------------------------------------------------------------------------
// ksubset_lex_unrank: k-subset lexicographic unranking
// Turns a rank into the ascending elements of the matching k-subset of {1..n}.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The rank is checked
// against C(n,k) in the cycle after the transfer; elements then come out in
// ascending order, one per valid strobe, the k-th with last set. An invalid
// request (k = 0, k > n, n > MAX_SET or rank >= C(n,k)) gives one result with
// error set, element 0, position 1 and last set, its valid registered from the
// range check. The walk steps through the candidates one at a time, with a
// binomial rom read feeding each compare, and busy stays high until the largest
// element is found; the final strobe comes in the first cycle with busy low
// again. Results cannot be held off: each strobe lasts exactly one cycle.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module ksubset_lex_unrank import ksl_pkg::*; #(
	parameter int MAX_SET = MAX_SET_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [RANK_W-1:0] rank,
	output logic              valid,
	output logic [CFG_W-1:0]  element,
	output logic [CFG_W-1:0]  position,
	output logic              last,
	output logic              error,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	ksl_cmd_t  cmd;
	ksl_stat_t stat;

	assign cfg_ready = 1'b1;

	ksl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ksl_dp #(
		.MAX_SET (MAX_SET)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rank      (rank),
		.cmd       (cmd),
		.stat      (stat),
		.valid     (valid),
		.element   (element),
		.position  (position),
		.last      (last),
		.error     (error)
	);

endmodule

`default_nettype wire

// File: design/ksl_checker.sv
// ----------------------------------------------------------------------------
// ksl_checker: port-level checks for the unranking block
// Watches the request and result ports and flags inconsistent sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module ksl_checker import ksl_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             valid,
	input logic [CFG_W-1:0] element,
	input logic [CFG_W-1:0] position,
	input logic             last,
	input logic             error
);

	// an error result is a lone, final result with fixed fields
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		valid && error |-> last && (element == '0) && (position == 6'd1))
		else $error("error result with unexpected fields");

	// more elements follow, so the block must still be working
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("non-final result while idle");

	// results only come from a request in progress
	a_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result without a request in progress");

	// a transfer always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request transfer did not start work");

	// positions count up from one within a request, so none may be zero
	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (position != '0))
		else $error("result with position zero");

endmodule

bind ksubset_lex_unrank ksl_checker u_ksl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.valid    (valid),
	.element  (element),
	.position (position),
	.last     (last),
	.error    (error)
);

`default_nettype wire
